>>> rtl/ptc_pkg.sv
// Shared types and constants for the pressure and temperature compensation block.
package ptc_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 64;
  localparam int unsigned DivBits = 64;

  typedef enum logic [1:0] {
    RegTempCalib   = 2'd0,
    RegPressCalibA = 2'd1,
    RegPressCalibB = 2'd2,
    RegPressCalibC = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } ptc_in_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi;
    logic signed [63:0] pressure_q24_8;
    logic               divide_by_zero;
  } ptc_out_t;

  typedef struct packed {
    logic signed [31:0] tf;
    logic signed [31:0] tc;
    logic               dz;
    logic               neg;
  } side_t;

endpackage

>>> rtl/pressure_temperature_compensation.sv
// Top level: register file, pipeline stages and output register for sensor compensation.
// Pipeline: 3 temperature stages, 5 pre-divide, 64 divider, 5 post-divide and 1 output
// register; the 64-stage divider sets the depth.
// Throughput: one beat per cycle; all stages advance together when the output
// register is empty or its beat is taken.
// Reset clears all valid bits and calibration registers; no clearing pass.
module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ptc_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ptc_out_t         out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [47:0]        temp_calib_q;
  logic [63:0]        press_calib_a_q, press_calib_b_q;
  logic [15:0]        press_calib_c_q;
  reg_idx_e           idx;
  logic               en;
  logic               t_valid, p_valid, d_valid, o_valid;
  logic signed [31:0] tf;
  logic [19:0]        adcp;
  logic [63:0]        mn, md, quo;
  side_t              p_side, d_side;
  ptc_out_t           o_data, out_q;
  logic               out_valid_q;
  logic signed [31:0] chk_tc;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q    <= '0;
      press_calib_a_q <= '0;
      press_calib_b_q <= '0;
      press_calib_c_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        RegTempCalib:   temp_calib_q    <= pwdata[47:0];
        RegPressCalibA: press_calib_a_q <= pwdata;
        RegPressCalibB: press_calib_b_q <= pwdata;
        RegPressCalibC: press_calib_c_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegTempCalib:   prdata = {16'd0, temp_calib_q};
      RegPressCalibA: prdata = press_calib_a_q;
      RegPressCalibB: prdata = press_calib_b_q;
      RegPressCalibC: prdata = {48'd0, press_calib_c_q};
      default:        prdata = '0;
    endcase
  end

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  ptc_temp u_temp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .in_i(in_data_i),
    .temp_calib_i(temp_calib_q), .valid_o(t_valid), .tf_o(tf), .adcp_o(adcp)
  );

  ptc_pre u_pre (
    .clk_i, .rst_ni, .en_i(en), .valid_i(t_valid), .tf_i(tf), .adcp_i(adcp),
    .press_calib_a_i(press_calib_a_q), .press_calib_b_i(press_calib_b_q),
    .valid_o(p_valid), .mn_o(mn), .md_o(md), .side_o(p_side)
  );

  ptc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_valid), .mn_i(mn), .md_i(md),
    .side_i(p_side), .valid_o(d_valid), .q_o(quo), .side_o(d_side)
  );

  ptc_post u_post (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_valid), .q_i(quo), .side_i(d_side),
    .press_calib_b_i(press_calib_b_q), .press_calib_c_i(press_calib_c_q),
    .valid_o(o_valid), .out_o(o_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= o_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= o_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign chk_tc = (out_q.fine_temperature * 32'sd5 + 32'sd128) >>> 8;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.divide_by_zero |-> out_q.pressure_q24_8 == 64'sd0)
    else $error("divide flag set with nonzero pressure");

  a_temp_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.temperature_centi == chk_tc)
    else $error("temperature fields out of step");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_q)
    else $error("result lost during stall");

endmodule

>>> rtl/ptc_temp.sv
// Temperature compensation pipeline: three stages from raw reading to fine temperature.
module ptc_temp import ptc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ptc_in_t            in_i,
  input  logic [47:0]        temp_calib_i,
  output logic               valid_o,
  output logic signed [31:0] tf_o,
  output logic [19:0]        adcp_o
);

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic signed [18:0] a_s;
  logic signed [17:0] b_s;
  logic signed [31:0] m1_d, m1_q, bb_d, bb_q;
  logic signed [31:0] tv1_d, tv1_q, sh, m2_d, m2_q, tf_d, tf_q;
  logic [19:0]        adcp1_q, adcp2_q, adcp3_q;
  logic [2:0]         vld_q;

  assign t1 = temp_calib_i[15:0];
  assign t2 = $signed(temp_calib_i[31:16]);
  assign t3 = $signed(temp_calib_i[47:32]);

  always_comb begin
    a_s   = $signed({2'b00, in_i.raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
    b_s   = $signed({2'b00, in_i.raw_temperature[19:4]}) - $signed({2'b00, t1});
    m1_d  = a_s * t2;
    bb_d  = b_s * b_s;
    tv1_d = m1_q >>> 11;
    sh    = bb_q >>> 12;
    m2_d  = sh * t3;
    tf_d  = tv1_q + (m2_q >>> 14);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= m1_d;
      bb_q    <= bb_d;
      adcp1_q <= in_i.raw_pressure;
      tv1_q   <= tv1_d;
      m2_q    <= m2_d;
      adcp2_q <= adcp1_q;
      tf_q    <= tf_d;
      adcp3_q <= adcp2_q;
    end
  end

  assign valid_o = vld_q[2];
  assign tf_o    = tf_q;
  assign adcp_o  = adcp3_q;

endmodule

>>> rtl/ptc_pre.sv
// Pressure terms ahead of the division: five stages down to divisor and dividend magnitudes.
module ptc_pre import ptc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] tf_i,
  input  logic [19:0]        adcp_i,
  input  logic [63:0]        press_calib_a_i,
  input  logic [63:0]        press_calib_b_i,
  output logic               valid_o,
  output logic [63:0]        mn_o,
  output logic [63:0]        md_o,
  output side_t              side_o
);

  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6;
  logic signed [63:0] p1x, p4x;
  logic signed [33:0] v1;
  logic signed [63:0] vv_d, vv_q, vp5_d, vp5_q, vp2_d, vp2_q;
  logic signed [63:0] v2a_d, v2a_q, v1a_d, v1a_q;
  logic signed [63:0] w, prod, v1b_d, v1b_q, num0_d, num0_q;
  logic signed [63:0] num_d, num_q, den_q;
  logic [20:0]        n21;
  logic [63:0]        mn_d, mn_q, md_d, md_q;
  logic [19:0]        adcp1_q, adcp2_q;
  side_t              s1_d, s1_q, s2_q, s3_q, s4_d, s4_q, s5_d, s5_q;
  logic [4:0]         vld_q;

  assign p1  = press_calib_a_i[15:0];
  assign p2  = $signed(press_calib_a_i[31:16]);
  assign p3  = $signed(press_calib_a_i[47:32]);
  assign p4  = $signed(press_calib_a_i[63:48]);
  assign p5  = $signed(press_calib_b_i[15:0]);
  assign p6  = $signed(press_calib_b_i[31:16]);
  assign p1x = $signed({48'd0, p1});
  assign p4x = p4;

  always_comb begin
    v1        = tf_i - 34'sd128000;
    vv_d      = v1 * v1;
    vp5_d     = v1 * p5;
    vp2_d     = v1 * p2;
    s1_d      = '0;
    s1_d.tf   = tf_i;
    s1_d.tc   = (tf_i * 32'sd5 + 32'sd128) >>> 8;

    v2a_d     = vv_q * p6 + (vp5_q <<< 17) + (p4x <<< 35);
    v1a_d     = ((vv_q * p3) >>> 8) + (vp2_q <<< 12);

    w         = 64'sh0000_8000_0000_0000 + v1a_q;
    prod      = w * p1x;
    v1b_d     = prod >>> 33;
    n21       = 21'd1048576 - {1'b0, adcp2_q};
    num0_d    = $signed({12'd0, n21, 31'd0}) - v2a_q;

    num_d     = num0_q * 64'sd3125;
    s4_d      = s3_q;
    s4_d.dz   = (v1b_q == 64'sd0);

    mn_d      = num_q[63] ? 64'(-num_q) : 64'(num_q);
    md_d      = s4_q.dz ? 64'd1 : (den_q[63] ? 64'(-den_q) : 64'(den_q));
    s5_d      = s4_q;
    s5_d.neg  = num_q[63] ^ den_q[63];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vv_q    <= vv_d;
      vp5_q   <= vp5_d;
      vp2_q   <= vp2_d;
      s1_q    <= s1_d;
      adcp1_q <= adcp_i;
      v2a_q   <= v2a_d;
      v1a_q   <= v1a_d;
      s2_q    <= s1_q;
      adcp2_q <= adcp1_q;
      v1b_q   <= v1b_d;
      num0_q  <= num0_d;
      s3_q    <= s2_q;
      num_q   <= num_d;
      den_q   <= v1b_q;
      s4_q    <= s4_d;
      mn_q    <= mn_d;
      md_q    <= md_d;
      s5_q    <= s5_d;
    end
  end

  assign valid_o = vld_q[4];
  assign mn_o    = mn_q;
  assign md_o    = md_q;
  assign side_o  = s5_q;

endmodule

>>> rtl/ptc_div.sv
// Pipelined restoring divider: one quotient bit per stage on unsigned magnitudes.
module ptc_div import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] mn_i,
  input  logic [63:0] md_i,
  input  side_t       side_i,
  output logic        valid_o,
  output logic [63:0] q_o,
  output side_t       side_o
);

  logic [63:0] rem_q  [DivBits];
  logic [63:0] quo_q  [DivBits];
  logic [63:0] den_q  [DivBits];
  side_t       side_q [DivBits];
  logic [DivBits-1:0] vld_q;

  for (genvar k = 0; k < DivBits; k++) begin : g_stage
    logic [63:0] r_in, q_in, d_in;
    side_t       s_in;
    logic        v_in;
    logic [64:0] shifted, diff;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = mn_i;
      assign d_in = md_i;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = den_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = vld_q[k-1];
    end

    assign shifted = {r_in, q_in[63]};
    assign diff    = shifted - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[64]) begin
          rem_q[k] <= diff[63:0];
          quo_q[k] <= {q_in[62:0], 1'b1};
        end else begin
          rem_q[k] <= shifted[63:0];
          quo_q[k] <= {q_in[62:0], 1'b0};
        end
        den_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[DivBits-1];
  assign q_o     = quo_q[DivBits-1];
  assign side_o  = side_q[DivBits-1];

endmodule

>>> rtl/ptc_post.sv
// Pressure terms after the division: five stages to the final Q24.8 pressure.
module ptc_post import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] q_i,
  input  side_t       side_i,
  input  logic [63:0] press_calib_b_i,
  input  logic [15:0] press_calib_c_i,
  output logic        valid_o,
  output ptc_out_t    out_o
);

  logic signed [15:0] p7, p8, p9;
  logic signed [63:0] p7x;
  logic signed [63:0] p0_d, p0_q, p1_q, p2_q, p3_q;
  logic signed [63:0] qs_d, qs_q, m8_d, m8_q, m8b_q, m8c_q;
  logic [63:0]        sqlo_d, sqlo_q, qq_d, qq_q;
  logic [31:0]        cross_d, cross_q;
  logic signed [63:0] t9, sum_d, sum_q;
  side_t              s0_q, s1_q, s2_q, s3_q, s4_q;
  logic [4:0]         vld_q;

  assign p7  = $signed(press_calib_b_i[47:32]);
  assign p8  = $signed(press_calib_b_i[63:48]);
  assign p9  = $signed(press_calib_c_i);
  assign p7x = p7;

  always_comb begin
    p0_d    = side_i.neg ? $signed(64'(-q_i)) : $signed(q_i);
    qs_d    = p0_q >>> 13;
    m8_d    = p8 * p0_q;
    sqlo_d  = {32'd0, qs_q[31:0]} * {32'd0, qs_q[31:0]};
    cross_d = qs_q[63:32] * qs_q[31:0];
    qq_d    = sqlo_q + {cross_q[30:0], 33'd0};
    t9      = (p9 * $signed(qq_q)) >>> 25;
    sum_d   = p3_q + t9 + (m8c_q >>> 19);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q    <= p0_d;
      s0_q    <= side_i;
      qs_q    <= qs_d;
      m8_q    <= m8_d;
      p1_q    <= p0_q;
      s1_q    <= s0_q;
      sqlo_q  <= sqlo_d;
      cross_q <= cross_d;
      m8b_q   <= m8_q;
      p2_q    <= p1_q;
      s2_q    <= s1_q;
      qq_q    <= qq_d;
      m8c_q   <= m8b_q;
      p3_q    <= p2_q;
      s3_q    <= s2_q;
      sum_q   <= sum_d;
      s4_q    <= s3_q;
    end
  end

  always_comb begin
    out_o.fine_temperature  = s4_q.tf;
    out_o.temperature_centi = s4_q.tc;
    out_o.divide_by_zero    = s4_q.dz;
    out_o.pressure_q24_8    = s4_q.dz ? 64'sd0 : (sum_q >>> 8) + (p7x <<< 4);
  end

  assign valid_o = vld_q[4];

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the pressure and temperature compensation block.
`timescale 1ns / 100ps

module testbench;
  import ptc_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned Latency   = 78;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  ptc_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  ptc_out_t         out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic [47:0] cal_temp;
  logic [63:0] cal_pa;
  logic [63:0] cal_pb;
  logic [15:0] cal_pc;

  ptc_out_t    comp_q[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned stall_phase;

  stim_row_t corner_rows[12] = '{
    '{20'h00000, 20'h00000}, '{20'hFFFFF, 20'hFFFFF}, '{20'h00000, 20'hFFFFF},
    '{20'hFFFFF, 20'h00000}, '{20'hAAAAA, 20'h55555}, '{20'h55555, 20'hAAAAA},
    '{20'h80000, 20'h7FFFF}, '{20'h7FFFF, 20'h80000}, '{20'h00001, 20'h00001},
    '{20'h7E8C0, 20'h65A40}, '{20'h84000, 20'h52000}, '{20'h6B000, 20'h80000}
  };

  pressure_temperature_compensation DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  function automatic logic [63:0] sext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic ptc_out_t compensate(ptc_in_t d);
    logic [31:0] adct, t1, t2, t3, a, b, m, tv1, tv2, tf, tc;
    logic [63:0] adcp, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, x, y, p, q, num, mn, md, quo;
    ptc_out_t    r;
    adct = {12'd0, d.raw_temperature};
    adcp = {44'd0, d.raw_pressure};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    a = (adct >> 3) - (t1 << 1);
    m = a * t2;
    tv1 = $signed(m) >>> 11;
    b = (adct >> 4) - t1;
    m = b * b;
    m = $signed(m) >>> 12;
    m = m * t3;
    tv2 = $signed(m) >>> 14;
    tf = tv1 + tv2;
    m = tf * 32'd5 + 32'd128;
    tc = $signed(m) >>> 8;
    p1 = {48'd0, cal_pa[15:0]};
    p2 = sext16(cal_pa[31:16]);
    p3 = sext16(cal_pa[47:32]);
    p4 = sext16(cal_pa[63:48]);
    p5 = sext16(cal_pb[15:0]);
    p6 = sext16(cal_pb[31:16]);
    p7 = sext16(cal_pb[47:32]);
    p8 = sext16(cal_pb[63:48]);
    p9 = sext16(cal_pc);
    v1 = {{32{tf[31]}}, tf} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    x = v1 * v1 * p3;
    x = $signed(x) >>> 8;
    v1 = x + ((v1 * p2) << 12);
    x = (64'h0000_8000_0000_0000 + v1) * p1;
    v1 = $signed(x) >>> 33;
    r.fine_temperature  = tf;
    r.temperature_centi = tc;
    if (v1 == 64'd0) begin
      r.pressure_q24_8 = '0;
      r.divide_by_zero = 1'b1;
    end else begin
      p = 64'd1048576 - adcp;
      num = ((p << 31) - v2) * 64'd3125;
      mn = num[63] ? -num : num;
      md = v1[63] ? -v1 : v1;
      quo = mn / md;
      p = (num[63] != v1[63]) ? -quo : quo;
      q = $signed(p) >>> 13;
      x = p9 * q * q;
      x = $signed(x) >>> 25;
      y = p8 * p;
      y = $signed(y) >>> 19;
      p = p + x + y;
      p = $signed(p) >>> 8;
      r.pressure_q24_8 = p + (p7 << 4);
      r.divide_by_zero = 1'b0;
    end
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    stall_phase = stall_phase + 1;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case ((stall_phase / 97) % 4)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(1) == 0);
        2: out_ready_i <= ($urandom_range(3) == 0);
        default: out_ready_i <= ((stall_phase % 5) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    ptc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (comp_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat %h", out_data_o);
      end else begin
        want = comp_q.pop_front();
        if (want.fine_temperature !== out_data_o.fine_temperature ||
            want.temperature_centi !== out_data_o.temperature_centi ||
            want.pressure_q24_8 !== out_data_o.pressure_q24_8 ||
            want.divide_by_zero !== out_data_o.divide_by_zero) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("mismatch fine exp %0d got %0d, centi exp %0d got %0d",
                     want.fine_temperature, out_data_o.fine_temperature,
                     want.temperature_centi, out_data_o.temperature_centi);
            $display("  pressure exp %0d got %0d, div0 exp %b got %b",
                     want.pressure_q24_8, out_data_o.pressure_q24_8,
                     want.divide_by_zero, out_data_o.divide_by_zero);
          end
        end
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(8 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegTempCalib:   cal_temp = value[47:0];
      RegPressCalibA: cal_pa   = value;
      RegPressCalibB: cal_pb   = value;
      RegPressCalibC: cal_pc   = value[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_calib(logic [63:0] t, logic [63:0] a, logic [63:0] b,
                            logic [63:0] c);
    while (comp_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
    write_reg(RegTempCalib, t);
    write_reg(RegPressCalibA, a);
    write_reg(RegPressCalibB, b);
    write_reg(RegPressCalibC, c);
  endtask

  task automatic send_beat(ptc_in_t d, bit fixed, ptc_out_t fixed_res, bit gaps);
    if (gaps && burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      if ($urandom_range(1) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left = burst_left - 1;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    comp_q.push_back(fixed ? fixed_res : compensate(d));
  endtask

  task automatic random_items(int unsigned count, bit gaps);
    ptc_in_t d;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        d.raw_temperature = 20'($urandom);
        d.raw_pressure    = 20'($urandom);
      end else begin
        d.raw_temperature = 20'($urandom_range(600000, 400000));
        d.raw_pressure    = 20'($urandom_range(450000, 250000));
      end
      send_beat(d, 1'b0, '0, gaps);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    ptc_in_t  d;
    ptc_out_t at_reset;
    mismatches   = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    hold_request = 0;
    hold_left    = 0;
    stall_phase  = 0;
    cal_temp = '0;
    cal_pa   = '0;
    cal_pb   = '0;
    cal_pc   = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    at_reset = '{fine_temperature: 32'sd0, temperature_centi: 32'sd0,
                 pressure_q24_8: 64'sd0, divide_by_zero: 1'b1};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_rows[i]) begin
      d = {corner_rows[i].raw_t, corner_rows[i].raw_p};
      send_beat(d, 1'b1, at_reset, 1'b0);
    end
    in_valid_i <= 1'b0;

    load_calib(64'hFFFF_FC18_6753_6B70, 64'h0B27_0BD0_D643_8E7D,
               64'hC6F8_3C8C_FFF9_008C, 64'hFFFF_FFFF_FFFF_1770);
    foreach (corner_rows[i]) begin
      d = {corner_rows[i].raw_t, corner_rows[i].raw_p};
      send_beat(d, 1'b0, '0, 1'b0);
    end
    random_items(150, 1'b1);

    hold_request = 400;
    random_items(200, 1'b0);

    load_calib('1, '1, '1, '1);
    random_items(80, 1'b1);
    load_calib(64'h0000_7FFF_8000_FFFF, 64'h8000_7FFF_8000_FFFF,
               64'h7FFF_8000_7FFF_8000, 64'h0000_0000_0000_7FFF);
    random_items(80, 1'b1);
    load_calib(64'h0000_8000_7FFF_0001, 64'h7FFF_8000_7FFF_0001,
               64'h8000_7FFF_8000_7FFF, 64'h0000_0000_0000_8000);
    random_items(80, 1'b1);
    for (int k = 0; k < 6; k++) begin
      load_calib({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      random_items(80, 1'b1);
    end
    load_calib(64'h0000_FC18_6753_6B70, 64'h0B27_0BD0_D643_8E7D,
               64'hC6F8_3C8C_FFF9_008C, 64'h0000_0000_0000_1770);
    random_items(160, 1'b1);

    while (comp_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (mismatches == 0 && comp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ptc_pkg.sv
rtl/ptc_temp.sv
rtl/ptc_pre.sv
rtl/ptc_div.sv
rtl/ptc_post.sv
rtl/pressure_temperature_compensation.sv
bench/testbench.sv
